// ===== rtl/etmm_pkg.sv =====
// ----------------------------------------------------------------------------
// etmm_pkg
// shared types and constants of the model matrix pipeline
// ----------------------------------------------------------------------------
package etmm_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ANGLE_W = 16;

  // rotation-mode cordic, q2.30, angles in 2^32 steps per turn
  localparam int unsigned CORDIC_STEPS = 24;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  typedef struct packed {
    logic        [ANGLE_W-1:0] angle_x;
    logic        [ANGLE_W-1:0] angle_y;
    logic        [ANGLE_W-1:0] angle_z;
    logic signed [DATA_W-1:0]  scale_x;
    logic signed [DATA_W-1:0]  scale_y;
    logic signed [DATA_W-1:0]  scale_z;
    logic signed [DATA_W-1:0]  pos_x;
    logic signed [DATA_W-1:0]  pos_y;
    logic signed [DATA_W-1:0]  pos_z;
  } trs_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] m00;
    logic signed [DATA_W-1:0] m01;
    logic signed [DATA_W-1:0] m02;
    logic signed [DATA_W-1:0] m03;
    logic signed [DATA_W-1:0] m10;
    logic signed [DATA_W-1:0] m11;
    logic signed [DATA_W-1:0] m12;
    logic signed [DATA_W-1:0] m13;
    logic signed [DATA_W-1:0] m20;
    logic signed [DATA_W-1:0] m21;
    logic signed [DATA_W-1:0] m22;
    logic signed [DATA_W-1:0] m23;
  } trs_res_t;

endpackage

// ===== rtl/euler_trs_model_matrix.sv =====
// ----------------------------------------------------------------------------
// euler_trs_model_matrix
// model matrix T*Rz*Rx*Ry*S from binary angles, scales and translation
// ----------------------------------------------------------------------------
// result strobe: valid_o marks the result of each start transfer
// throughput: one transfer per cycle, busy_o is always low
// the 24 cordic steps run three per stage over 8 stages, then 6 stages of
// rounding, multiplies, sums and saturation
// reset clears only the valid bits; the receiver cannot stall the pipeline
module euler_trs_model_matrix #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  etmm_pkg::trs_in_t  in_i,
  output logic               busy_o,
  output logic               valid_o,
  output etmm_pkg::trs_res_t res_o
);
  import etmm_pkg::*;

  // widths of the fixed-point path
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned CW  = F + 2;        // cos, sin and rotation entries
  localparam int unsigned PW  = 2 * CW;       // product of two entries
  localparam int unsigned SW  = CW + DATA_W;  // entry times scale
  localparam int unsigned XW  = 34;           // cordic x and y, q2.30 plus growth
  localparam int unsigned NCS = 8;            // cordic stages
  localparam int unsigned SPS = CORDIC_STEPS / NCS;
  localparam int unsigned LAST = NCS + 6;     // output stage index

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  typedef struct packed {
    logic signed [2:0][DATA_W-1:0] scale;
    logic signed [2:0][DATA_W-1:0] pos;
  } side_t;

  // round a sum of products with 2F fraction bits down to F
  function automatic logic signed [CW-1:0] rnd_p(input logic signed [PW:0] v);
    logic signed [PW:0] t;
    t = v + (PW+1)'(1 << (F - 1));
    return CW'(t >>> F);
  endfunction

  // ---------------------------------------------------------------- control
  logic [LAST:0] vld_q;
  side_t         sd_q [LAST];

  assign busy_o  = 1'b0;
  assign valid_o = vld_q[LAST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAST-1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    sd_q[0] <= '{scale: {in_i.scale_z, in_i.scale_y, in_i.scale_x},
                 pos:   {in_i.pos_z, in_i.pos_y, in_i.pos_x}};
    for (int s = 1; s < LAST; s++) begin
      sd_q[s] <= sd_q[s-1];
    end
  end

  // ---------------------------------------------------------------- stage 0
  // angles widened to a 32-bit turn; the shift drops bits above ANGLE_BITS
  logic signed [XW-1:0] x_q    [NCS+1][3];
  logic signed [XW-1:0] y_q    [NCS+1][3];
  logic signed [31:0]   z_q    [NCS+1][3];
  logic        [1:0]    quad_q [NCS+1][3];
  logic        [31:0]   turn   [3];

  always_comb begin
    turn[0] = 32'(in_i.angle_x) << (32 - ANGLE_BITS);
    turn[1] = 32'(in_i.angle_y) << (32 - ANGLE_BITS);
    turn[2] = 32'(in_i.angle_z) << (32 - ANGLE_BITS);
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      x_q[0][a]    <= XW'(CORDIC_GAIN);
      y_q[0][a]    <= '0;
      z_q[0][a]    <= $signed({2'b00, turn[a][29:0]});
      quad_q[0][a] <= turn[a][31:30];
    end
  end

  // ---------------------------------------------------------------- cordic
  for (genvar g = 1; g <= NCS; g++) begin : g_cordic
    logic signed [XW-1:0] xn [3];
    logic signed [XW-1:0] yn [3];
    logic signed [31:0]   zn [3];

    always_comb begin : step
      logic signed [XW-1:0] xt, yt, dx, dy;
      logic signed [31:0]   zt;
      for (int a = 0; a < 3; a++) begin
        xt = x_q[g-1][a];
        yt = y_q[g-1][a];
        zt = z_q[g-1][a];
        for (int j = 0; j < SPS; j++) begin
          dx = yt >>> ((g - 1) * SPS + j);
          dy = xt >>> ((g - 1) * SPS + j);
          if (!zt[31]) begin
            xt = xt - dx;
            yt = yt + dy;
            zt = zt - ATAN_TURN[(g - 1) * SPS + j];
          end else begin
            xt = xt + dx;
            yt = yt - dy;
            zt = zt + ATAN_TURN[(g - 1) * SPS + j];
          end
        end
        xn[a] = xt;
        yn[a] = yt;
        zn[a] = zt;
      end
    end

    always_ff @(posedge clk_i) begin
      for (int a = 0; a < 3; a++) begin
        x_q[g][a]    <= xn[a];
        y_q[g][a]    <= yn[a];
        z_q[g][a]    <= zn[a];
        quad_q[g][a] <= quad_q[g-1][a];
      end
    end
  end

  // ---------------------------------------------------------------- p1
  // round to q.F and unfold the quadrant
  logic signed [CW-1:0] c1_q [3], s1_q [3];
  logic signed [CW-1:0] cr [3], sr [3];
  logic signed [CW-1:0] cm [3], sm [3];
  logic signed [XW-1:0] xr [3], yr [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      xr[a] = x_q[NCS][a] + XW'(1 << (29 - F));
      yr[a] = y_q[NCS][a] + XW'(1 << (29 - F));
      cr[a] = CW'(xr[a] >>> (30 - F));
      sr[a] = CW'(yr[a] >>> (30 - F));
      case (quad_q[NCS][a])
        QUAD_0: begin
          cm[a] = cr[a];
          sm[a] = sr[a];
        end
        QUAD_1: begin
          cm[a] = -sr[a];
          sm[a] = cr[a];
        end
        QUAD_2: begin
          cm[a] = -cr[a];
          sm[a] = -sr[a];
        end
        default: begin
          cm[a] = sr[a];
          sm[a] = -cr[a];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q <= cm;
    s1_q <= sm;
  end

  // ---------------------------------------------------------------- p2
  // a = sx*sy and b = sx*cy, rounded
  logic signed [CW-1:0] c2_q [3], s2_q [3];
  logic signed [CW-1:0] a_q, b_q;
  logic signed [PW-1:0] pa, pb;

  assign pa = PW'(s1_q[0]) * PW'(s1_q[1]);
  assign pb = PW'(s1_q[0]) * PW'(c1_q[1]);

  always_ff @(posedge clk_i) begin
    c2_q <= c1_q;
    s2_q <= s1_q;
    a_q  <= rnd_p((PW+1)'(pa));
    b_q  <= rnd_p((PW+1)'(pb));
  end

  // ---------------------------------------------------------------- p3
  // twelve products of the rotation terms
  logic signed [CW-1:0] sx3_q;
  logic signed [PW-1:0] czcy_q, sza_q, czsy_q, szb_q, szcy_q, cza_q;
  logic signed [PW-1:0] szsy_q, czb_q, szcx_q, czcx_q, cxsy_q, cxcy_q;

  always_ff @(posedge clk_i) begin
    sx3_q  <= s2_q[0];
    czcy_q <= PW'(c2_q[2]) * PW'(c2_q[1]);
    sza_q  <= PW'(s2_q[2]) * PW'(a_q);
    czsy_q <= PW'(c2_q[2]) * PW'(s2_q[1]);
    szb_q  <= PW'(s2_q[2]) * PW'(b_q);
    szcy_q <= PW'(s2_q[2]) * PW'(c2_q[1]);
    cza_q  <= PW'(c2_q[2]) * PW'(a_q);
    szsy_q <= PW'(s2_q[2]) * PW'(s2_q[1]);
    czb_q  <= PW'(c2_q[2]) * PW'(b_q);
    szcx_q <= PW'(s2_q[2]) * PW'(c2_q[0]);
    czcx_q <= PW'(c2_q[2]) * PW'(c2_q[0]);
    cxsy_q <= PW'(c2_q[0]) * PW'(s2_q[1]);
    cxcy_q <= PW'(c2_q[0]) * PW'(c2_q[1]);
  end

  // ---------------------------------------------------------------- p4
  // rotation entries, row major
  logic signed [CW-1:0] rot_q [9];

  always_ff @(posedge clk_i) begin
    rot_q[0] <= rnd_p((PW+1)'(czcy_q) - (PW+1)'(sza_q));
    rot_q[1] <= rnd_p(-(PW+1)'(szcx_q));
    rot_q[2] <= rnd_p((PW+1)'(czsy_q) + (PW+1)'(szb_q));
    rot_q[3] <= rnd_p((PW+1)'(szcy_q) + (PW+1)'(cza_q));
    rot_q[4] <= rnd_p((PW+1)'(czcx_q));
    rot_q[5] <= rnd_p((PW+1)'(szsy_q) - (PW+1)'(czb_q));
    rot_q[6] <= rnd_p(-(PW+1)'(cxsy_q));
    rot_q[7] <= sx3_q;
    rot_q[8] <= rnd_p((PW+1)'(cxcy_q));
  end

  // ---------------------------------------------------------------- p5
  // each column times the scale of its axis
  logic signed [SW-1:0] scl_q [9];

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < 9; e++) begin
      scl_q[e] <= SW'(rot_q[e]) * SW'($signed(sd_q[LAST-2].scale[e % 3]));
    end
  end

  // ---------------------------------------------------------------- p6
  // round, saturate and register the result
  logic signed [SW-1:0]     sr6 [9];
  logic signed [DATA_W-1:0] sat [9];
  trs_res_t                 res_q;

  always_comb begin
    for (int e = 0; e < 9; e++) begin
      sr6[e] = (scl_q[e] + SW'(1 << (F - 1))) >>> F;
      if (sr6[e] > SW'(32'sh7fffffff)) begin
        sat[e] = 32'sh7fffffff;
      end else if (sr6[e] < -SW'(33'sh080000000)) begin
        sat[e] = 32'sh80000000;
      end else begin
        sat[e] = DATA_W'(sr6[e]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.m00 <= sat[0];
    res_q.m01 <= sat[1];
    res_q.m02 <= sat[2];
    res_q.m03 <= sd_q[LAST-1].pos[0];
    res_q.m10 <= sat[3];
    res_q.m11 <= sat[4];
    res_q.m12 <= sat[5];
    res_q.m13 <= sd_q[LAST-1].pos[1];
    res_q.m20 <= sat[6];
    res_q.m21 <= sat[7];
    res_q.m22 <= sat[8];
    res_q.m23 <= sd_q[LAST-1].pos[2];
  end

  assign res_o = res_q;

endmodule
